[src/bmg_pkg.sv]
// Shared types, codes and the xorshift32 step for the maze generator.
// No dependencies; used by bmg_ctrl, bmg_datapath and the top level.
package bmg_pkg;

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DIG  = 1'b1;

    // Wall read-modify-write target
    localparam logic [1:0] WSEL_CELL    = 2'd0;
    localparam logic [1:0] WSEL_NEW     = 2'd1;
    localparam logic [1:0] WSEL_BETWEEN = 2'd2;
    localparam logic [1:0] WSEL_EXTRA   = 2'd3;

    // Divisor select for the modulo unit
    localparam logic [1:0] DSEL_COUNT = 2'd0;
    localparam logic [1:0] DSEL_X     = 2'd1;
    localparam logic [1:0] DSEL_Y     = 2'd2;

    typedef struct packed {
        logic       load_seed;
        logic       start_dig;
        logic       init_wr;
        logic       set_origin;
        logic       draw;
        logic [1:0] dsel;
        logic       pop;
        logic       pop_load;
        logic       push;
        logic       adv_top;
        logic       rmw_rd;
        logic       rmw_wr;
        logic [1:0] wsel;
        logic       latch_x;
        logic       latch_y;
        logic       row_clr;
        logic       row_inc;
        logic       emit_rd;
        logic       emit_ld;
    } ctrl_t;

    typedef struct packed {
        logic depth_zero;
        logic cand_none;
        logic mod_busy;
        logic extra_done;
        logic extra_open;
        logic row_last;
        logic out_free;
    } status_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

[src/bmg_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bmg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/bmg_datapath.sv]
// Datapath: generator, modulo unit, visited bits, wall and stack RAMs, output register.
// Depends on bmg_pkg and bmg_ram; driven by bmg_ctrl.
module bmg_datapath #(
    parameter int CELLS_WIDE = 9,
    parameter int CELLS_HIGH = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bmg_pkg::ctrl_t                       cmd,
    output bmg_pkg::status_t                     st,
    input  logic [31:0]                          seed_value,
    input  logic [2:0]                           level,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic [$clog2(2*CELLS_HIGH+1)-1:0]    row_index,
    output logic [2*CELLS_WIDE:0]                row_walls,
    output logic                                 last
);

    localparam int GW   = 2 * CELLS_WIDE + 1;
    localparam int GH   = 2 * CELLS_HIGH + 1;
    localparam int NC   = CELLS_WIDE * CELLS_HIGH;
    localparam int XW   = $clog2(CELLS_WIDE);
    localparam int YW   = $clog2(CELLS_HIGH);
    localparam int AW   = $clog2(GH);
    localparam int CLW  = $clog2(GW);
    localparam int SAW  = $clog2(NC);
    localparam int DPW  = $clog2(NC + 1);
    localparam int GMAX = (GW > GH) ? GW : GH;
    localparam int DW   = $clog2(GMAX);

    // generator and modulo unit
    logic [31:0]   prng_reg;
    logic [31:0]   draw_val;
    logic [31:0]   mshift_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] div_reg;
    logic [DW-1:0] div_sel;
    logic [DW-1:0] rem_step;
    logic [1:0]    mcnt_reg;
    logic          mbusy_reg;

    // walk state
    logic [XW-1:0]  cx_reg, nx_reg;
    logic [YW-1:0]  cy_reg, ny_reg;
    logic [DPW-1:0] depth_reg;
    logic [NC-1:0]  visited_reg;
    logic [2:0]     lvl_reg;
    logic [3:0]     extra_cnt_reg;
    logic [CLW-1:0] ex_reg;
    logic [AW-1:0]  ey_reg;
    logic [AW-1:0]  ey_now;
    logic [AW-1:0]  row_reg;

    // candidates
    logic [XW-1:0]  cand_x [4];
    logic [YW-1:0]  cand_y [4];
    logic [3:0]     cand_in;
    logic [3:0]     cand_ok;
    logic [2:0]     cand_cnt;
    logic [XW-1:0]  sel_x;
    logic [YW-1:0]  sel_y;

    // wall RAM
    logic [AW-1:0]  op_row;
    logic [CLW-1:0] op_col;
    logic [GW-1:0]  op_mask;
    logic           w_we, w_re;
    logic [AW-1:0]  w_addr;
    logic [GW-1:0]  w_wdata, w_rdata;

    // stack RAM
    logic                 s_we, s_re;
    logic [SAW-1:0]       s_waddr, s_raddr;
    logic [XW+YW-1:0]     s_wdata, s_rdata;

    logic out_valid_reg;

    always_comb
    begin
        logic [SAW-1:0] idx;
        logic [2:0]     seen;
        cand_x[0] = XW'(int'(cx_reg) + 1);
        cand_y[0] = cy_reg;
        cand_in[0] = (int'(cx_reg) + 1) < CELLS_WIDE;
        cand_x[1] = XW'(int'(cx_reg) - 1);
        cand_y[1] = cy_reg;
        cand_in[1] = cx_reg != '0;
        cand_x[2] = cx_reg;
        cand_y[2] = YW'(int'(cy_reg) + 1);
        cand_in[2] = (int'(cy_reg) + 1) < CELLS_HIGH;
        cand_x[3] = cx_reg;
        cand_y[3] = YW'(int'(cy_reg) - 1);
        cand_in[3] = cy_reg != '0;
        cand_cnt = '0;
        sel_x = cand_x[0];
        sel_y = cand_y[0];
        seen = '0;
        for (int k = 0; k < 4; k++)
        begin
            idx = SAW'(int'(cand_y[k]) * CELLS_WIDE + int'(cand_x[k]));
            cand_ok[k] = cand_in[k] && !visited_reg[idx];
            if (cand_ok[k])
            begin
                if (DW'(seen) == rem_reg)
                begin
                    sel_x = cand_x[k];
                    sel_y = cand_y[k];
                end
                seen = seen + 3'd1;
            end
        end
        cand_cnt = seen;
    end

    // modulo: eight remainder steps per cycle, MSB first
    always_comb
    begin
        logic [DW:0] t;
        logic [DW-1:0] r;
        r = rem_reg;
        for (int i = 0; i < 8; i++)
        begin
            t = {r, mshift_reg[31-i]};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            r = t[DW-1:0];
        end
        rem_step = r;
    end

    assign draw_val = bmg_pkg::xorshift32(prng_reg);

    always_comb
    begin
        unique case (cmd.dsel)
            bmg_pkg::DSEL_COUNT: div_sel = DW'(cand_cnt);
            bmg_pkg::DSEL_X:     div_sel = DW'(GW - 2);
            bmg_pkg::DSEL_Y:     div_sel = DW'(GH - 2);
            default:             div_sel = DW'(GH - 2);
        endcase
    end

    always_comb
    begin
        unique case (cmd.wsel)
            bmg_pkg::WSEL_CELL:
            begin
                op_row = AW'(int'(cy_reg) * 2 + 1);
                op_col = CLW'(int'(cx_reg) * 2 + 1);
            end
            bmg_pkg::WSEL_NEW:
            begin
                op_row = AW'(int'(ny_reg) * 2 + 1);
                op_col = CLW'(int'(nx_reg) * 2 + 1);
            end
            bmg_pkg::WSEL_BETWEEN:
            begin
                op_row = AW'(int'(cy_reg) + int'(ny_reg) + 1);
                op_col = CLW'(int'(cx_reg) + int'(nx_reg) + 1);
            end
            default:
            begin
                op_row = ey_reg;
                op_col = ex_reg;
            end
        endcase
        op_mask = {{(GW-1){1'b0}}, 1'b1} << op_col;
    end

    assign w_we    = cmd.init_wr | cmd.rmw_wr;
    assign w_re    = cmd.rmw_rd | cmd.emit_rd;
    assign w_addr  = (cmd.rmw_rd | cmd.rmw_wr) ? op_row : row_reg;
    assign w_wdata = cmd.init_wr ? {GW{1'b1}} : (w_rdata & ~op_mask);

    bmg_ram #(.WIDTH(GW), .DEPTH(GH)) u_walls (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_addr),
        .wdata (w_wdata),
        .re    (w_re),
        .raddr (w_addr),
        .rdata (w_rdata)
    );

    assign s_we    = cmd.set_origin | cmd.push;
    assign s_waddr = cmd.set_origin ? '0 : depth_reg[SAW-1:0];
    assign s_wdata = cmd.set_origin ? '0 : {sel_y, sel_x};
    assign s_re    = cmd.pop && (depth_reg > DPW'(1));
    assign s_raddr = SAW'(depth_reg - DPW'(2));

    bmg_ram #(.WIDTH(XW + YW), .DEPTH(NC)) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign ey_now = AW'(int'(rem_reg) + 1);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prng_reg      <= 32'd1;
            depth_reg     <= '0;
            visited_reg   <= '0;
            mbusy_reg     <= 1'b0;
            mcnt_reg      <= '0;
            extra_cnt_reg <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_seed)
            begin
                prng_reg <= seed_value | 32'd1;
            end
            else if (cmd.draw)
            begin
                prng_reg <= draw_val;
            end
            if (cmd.draw)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= '0;
            end
            else if (mbusy_reg)
            begin
                mcnt_reg <= mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    mbusy_reg <= 1'b0;
                end
            end
            if (cmd.start_dig)
            begin
                visited_reg   <= '0;
                extra_cnt_reg <= '0;
            end
            if (cmd.set_origin)
            begin
                visited_reg[0] <= 1'b1;
                depth_reg      <= DPW'(1);
            end
            if (cmd.push)
            begin
                visited_reg[SAW'(int'(sel_y) * CELLS_WIDE + int'(sel_x))] <= 1'b1;
                depth_reg <= depth_reg + DPW'(1);
            end
            if (cmd.pop)
            begin
                depth_reg <= depth_reg - DPW'(1);
            end
            if (cmd.latch_y)
            begin
                extra_cnt_reg <= extra_cnt_reg + 4'd1;
            end
            if (cmd.start_dig || cmd.row_clr)
            begin
                row_reg <= '0;
            end
            else if (cmd.row_inc || cmd.emit_ld)
            begin
                row_reg <= row_reg + AW'(1);
            end
            if (cmd.emit_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.draw)
        begin
            mshift_reg <= draw_val;
            rem_reg    <= '0;
            div_reg    <= div_sel;
        end
        else if (mbusy_reg)
        begin
            mshift_reg <= mshift_reg << 8;
            rem_reg    <= rem_step;
        end
        if (cmd.start_dig)
        begin
            lvl_reg <= level;
        end
        if (cmd.set_origin)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else if (cmd.adv_top)
        begin
            cx_reg <= nx_reg;
            cy_reg <= ny_reg;
        end
        else if (cmd.pop_load)
        begin
            cx_reg <= s_rdata[XW-1:0];
            cy_reg <= s_rdata[XW+YW-1:XW];
        end
        if (cmd.push)
        begin
            nx_reg <= sel_x;
            ny_reg <= sel_y;
        end
        if (cmd.latch_x)
        begin
            ex_reg <= CLW'(int'(rem_reg) + 1);
        end
        if (cmd.latch_y)
        begin
            ey_reg <= ey_now;
        end
        if (cmd.emit_ld)
        begin
            row_index <= row_reg;
            row_walls <= w_rdata;
            last      <= (row_reg == AW'(GH - 1));
        end
    end

    assign out_valid     = out_valid_reg;
    assign st.depth_zero = depth_reg == '0;
    assign st.cand_none  = cand_cnt == 3'd0;
    assign st.mod_busy   = mbusy_reg;
    assign st.extra_done = extra_cnt_reg == (4'd4 + {1'b0, lvl_reg});
    assign st.extra_open = ex_reg[0] ^ ey_now[0];
    assign st.row_last   = row_reg == AW'(GH - 1);
    assign st.out_free   = !out_valid_reg || !out_stall;

endmodule

[src/bmg_ctrl.sv]
// Sequencer for the maze walk: init, depth-first walk, extra openings, row output.
// Depends on bmg_pkg; drives bmg_datapath through ctrl_t.
module bmg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             in_cmd,
    input  bmg_pkg::status_t st,
    output bmg_pkg::ctrl_t   cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_WR    = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_POPW  = 4'd6;
    localparam logic [3:0] S_MODW  = 4'd7;
    localparam logic [3:0] S_LINK  = 4'd8;
    localparam logic [3:0] S_ADV   = 4'd9;
    localparam logic [3:0] S_EXTRA = 4'd10;
    localparam logic [3:0] S_MODX  = 4'd11;
    localparam logic [3:0] S_MODY  = 4'd12;
    localparam logic [3:0] S_EMRD  = 4'd13;
    localparam logic [3:0] S_EMLD  = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;
    logic [1:0] wsel_reg, wsel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            wsel_reg  <= bmg_pkg::WSEL_CELL;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            wsel_reg  <= wsel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        wsel_next  = wsel_reg;
        cmd        = '0;
        cmd.wsel   = wsel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == bmg_pkg::CMD_DIG)
                    begin
                        cmd.start_dig = 1'b1;
                        state_next    = S_INIT;
                    end
                    else
                    begin
                        cmd.load_seed = 1'b1;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                cmd.row_inc = 1'b1;
                if (st.row_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.set_origin = 1'b1;
                wsel_next      = bmg_pkg::WSEL_CELL;
                ret_next       = S_WALK;
                state_next     = S_RD;
            end
            S_RD:
            begin
                cmd.rmw_rd = 1'b1;
                state_next = S_WR;
            end
            S_WR:
            begin
                cmd.rmw_wr = 1'b1;
                state_next = ret_reg;
            end
            S_WALK:
            begin
                if (st.depth_zero)
                begin
                    state_next = S_EXTRA;
                end
                else if (st.cand_none)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POPW;
                end
                else
                begin
                    cmd.draw   = 1'b1;
                    cmd.dsel   = bmg_pkg::DSEL_COUNT;
                    state_next = S_MODW;
                end
            end
            S_POPW:
            begin
                cmd.pop_load = 1'b1;
                state_next   = S_WALK;
            end
            S_MODW:
            begin
                if (!st.mod_busy)
                begin
                    cmd.push   = 1'b1;
                    wsel_next  = bmg_pkg::WSEL_NEW;
                    ret_next   = S_LINK;
                    state_next = S_RD;
                end
            end
            S_LINK:
            begin
                wsel_next  = bmg_pkg::WSEL_BETWEEN;
                ret_next   = S_ADV;
                state_next = S_RD;
            end
            S_ADV:
            begin
                cmd.adv_top = 1'b1;
                state_next  = S_WALK;
            end
            S_EXTRA:
            begin
                if (st.extra_done)
                begin
                    cmd.row_clr = 1'b1;
                    state_next  = S_EMRD;
                end
                else
                begin
                    cmd.draw   = 1'b1;
                    cmd.dsel   = bmg_pkg::DSEL_X;
                    state_next = S_MODX;
                end
            end
            S_MODX:
            begin
                if (!st.mod_busy)
                begin
                    cmd.latch_x = 1'b1;
                    cmd.draw    = 1'b1;
                    cmd.dsel    = bmg_pkg::DSEL_Y;
                    state_next  = S_MODY;
                end
            end
            S_MODY:
            begin
                if (!st.mod_busy)
                begin
                    cmd.latch_y = 1'b1;
                    if (st.extra_open)
                    begin
                        wsel_next  = bmg_pkg::WSEL_EXTRA;
                        ret_next   = S_EXTRA;
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_EXTRA;
                    end
                end
            end
            S_EMRD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMLD;
            end
            S_EMLD:
            begin
                if (st.out_free)
                begin
                    cmd.emit_ld = 1'b1;
                    state_next  = st.row_last ? S_IDLE : S_EMRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

[src/backtracker_maze_generator.sv]
// Top level of the maze generator: controller plus datapath.
// Depends on bmg_pkg, bmg_ctrl, bmg_datapath (and bmg_ram through it).
//
// Usage notes:
//  - Input channel (in_valid / in_stall): one transaction carries cmd,
//    seed_value and level. cmd load stores seed_value|1 as generator state
//    and gives no output. cmd dig builds a new maze.
//  - Output channel (out_valid / out_stall): a dig yields one transaction per
//    grid row, row_index 0 up to 2*CELLS_HIGH, with last set on the final row.
//  - in_stall is high from a dig until its last row sits in the output
//    register; only one transaction is worked on at a time.
//  - A dig runs the wall init, the depth-first walk, the extra openings and
//    the row output in that order. The walk is set by the draw and the
//    modulo unit (8 remainder bits per cycle) plus the two read-modify-write
//    passes per push on the wall RAM, whose read and write ports share one address.
//  - When the receiver stalls, the row in the output register holds and the
//    sequencer waits before loading the next row.
//  - Reset: generator state returns to 1, sequencer to idle, output empty.
//    Wall and stack RAMs need no clearing; every dig rewrites all rows.
module backtracker_maze_generator #(
    parameter int CELLS_WIDE = 9,
    parameter int CELLS_HIGH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [31:0]                       seed_value,
    input  logic [2:0]                        level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [$clog2(2*CELLS_HIGH+1)-1:0] row_index,
    output logic [2*CELLS_WIDE:0]             row_walls,
    output logic                              last
);

    bmg_pkg::ctrl_t   ctrl;
    bmg_pkg::status_t status;

    // sequencer
    bmg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_cmd   (cmd),
        .st       (status),
        .cmd      (ctrl)
    );

    // storage, generator, modulo unit and output register
    bmg_datapath #(
        .CELLS_WIDE (CELLS_WIDE),
        .CELLS_HIGH (CELLS_HIGH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctrl),
        .st         (status),
        .seed_value (seed_value),
        .level      (level),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .row_index  (row_index),
        .row_walls  (row_walls),
        .last       (last)
    );

endmodule

[sim/tb_backtracker_maze_generator.sv]
`timescale 1ns / 100ps
// Testbench for backtracker_maze_generator: directed table then random transactions,
// every row checked against an in-bench maze predictor. Depends on bmg_pkg and the RTL.
module tb_backtracker_maze_generator;

    localparam int CW = 9;
    localparam int CH = 4;
    localparam int GW = 2 * CW + 1;
    localparam int GH = 2 * CH + 1;
    localparam int NCELL = CW * CH;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [3:0]  idx;
        logic [18:0] walls;
        logic        fin;
    } maze_row_t;

    // directed row: command, seed, level
    typedef struct {
        logic        c;
        logic [31:0] sd;
        logic [2:0]  lv;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic cmd = bmg_pkg::CMD_LOAD;
    logic [31:0] seed_value = '0;
    logic [2:0] level = '0;
    logic out_stall = 1'b0;
    logic in_stall, out_valid, last;
    logic [3:0] row_index;
    logic [18:0] row_walls;

    backtracker_maze_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .seed_value(seed_value), .level(level),
        .out_valid(out_valid), .out_stall(out_stall),
        .row_index(row_index), .row_walls(row_walls), .last(last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // predictor state
    logic [31:0] gen_state;
    logic [18:0] grid [GH];
    maze_row_t rows_due [$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;

    function automatic logic [31:0] next_draw();
        logic [31:0] s;
        s = gen_state;
        s = s ^ (s << 13);
        s = s ^ (s >> 17);
        s = s ^ (s << 5);
        gen_state = s;
        return s;
    endfunction

    // Builds the maze exactly as the block should and queues its nine rows.
    task automatic dig_maze(input logic [2:0] lv);
        int stk [NCELL];
        int depth, cx, cy, nx, ny, cnt, pick, x, y;
        int cxs [4];
        int cys [4];
        int dx [4] = '{1, -1, 0, 0};
        int dy [4] = '{0, 0, 1, -1};
        maze_row_t r;
        for (int i = 0; i < GH; i++)
            grid[i] = '1;
        grid[1][1] = 1'b0;
        depth = 1;
        stk[0] = 0;
        while (depth > 0)
        begin
            cx = stk[depth-1] % CW;
            cy = stk[depth-1] / CW;
            cnt = 0;
            for (int k = 0; k < 4; k++)
            begin
                nx = cx + dx[k];
                ny = cy + dy[k];
                if (nx < 0 || ny < 0 || nx >= CW || ny >= CH)
                    continue;
                if (!grid[ny*2+1][nx*2+1])
                    continue;
                cxs[cnt] = nx;
                cys[cnt] = ny;
                cnt++;
            end
            if (cnt == 0)
            begin
                depth--;
                continue;
            end
            pick = next_draw() % cnt;
            nx = cxs[pick];
            ny = cys[pick];
            grid[ny*2+1][nx*2+1] = 1'b0;
            grid[cy+ny+1][cx+nx+1] = 1'b0;
            if (depth < NCELL)
            begin
                stk[depth] = ny * CW + nx;
                depth++;
            end
        end
        // extra openings make loops
        for (int i = 0; i < 4 + lv; i++)
        begin
            x = 1 + next_draw() % (GW - 2);
            y = 1 + next_draw() % (GH - 2);
            if (((x & 1) == 0) != ((y & 1) == 0))
                grid[y][x] = 1'b0;
        end
        for (int i = 0; i < GH; i++)
        begin
            r.idx = 4'(i);
            r.walls = grid[i];
            r.fin = (i == GH - 1);
            rows_due.push_back(r);
        end
    endtask

    task automatic note_mismatch(input string what, input maze_row_t want, input maze_row_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected idx %0d walls %05h last %0b, got idx %0d walls %05h last %0b",
                     what, want.idx, want.walls, want.fin, got.idx, got.walls, got.fin);
    endtask

    // one transaction on the input channel; updates the predictor on acceptance.
    // valid is left high; the caller drops it before any gap.
    task automatic send(input logic c, input logic [31:0] sd, input logic [2:0] lv);
        in_valid <= 1'b1;
        cmd <= c;
        seed_value <= sd;
        level <= lv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (c == bmg_pkg::CMD_LOAD)
            gen_state = sd | 32'd1;
        else
            dig_maze(lv);
        @(negedge clk);
    endtask

    task automatic short_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (n != 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Output side: compare every accepted row with the oldest one due.
    always @(posedge clk)
    begin
        maze_row_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{row_index, row_walls, last};
            if (rows_due.size() == 0)
                note_mismatch("unexpected row", '0, got);
            else
            begin
                want = rows_due.pop_front();
                if (got !== want)
                    note_mismatch("row", want, got);
            end
        end
    end

    // Receiver stalls: random gaps, or a forced long hold-off.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (1500) @(negedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 40) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 60)) @(negedge clk);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("backtracker_maze_generator: mismatch");
            $finish;
        end
    end

    stim_t plan [13] = '{
        '{bmg_pkg::CMD_DIG,  32'h0000_0000, 3'd0},  // dig straight after reset, state one
        '{bmg_pkg::CMD_DIG,  32'h0000_0000, 3'd7},
        '{bmg_pkg::CMD_LOAD, 32'h0000_0000, 3'd0},  // zero seed becomes one
        '{bmg_pkg::CMD_DIG,  32'h0000_0000, 3'd1},
        '{bmg_pkg::CMD_LOAD, 32'hFFFF_FFFF, 3'd7},
        '{bmg_pkg::CMD_DIG,  32'hFFFF_FFFF, 3'd7},
        '{bmg_pkg::CMD_LOAD, 32'h8000_0000, 3'd3},
        '{bmg_pkg::CMD_DIG,  32'h0000_0000, 3'd0},
        '{bmg_pkg::CMD_LOAD, 32'hA5A5_5A5A, 3'd5},
        '{bmg_pkg::CMD_DIG,  32'h1234_5678, 3'd4},
        '{bmg_pkg::CMD_LOAD, 32'h5A5A_A5A5, 3'd2},
        '{bmg_pkg::CMD_LOAD, 32'h0000_0001, 3'd6},  // back-to-back loads
        '{bmg_pkg::CMD_DIG,  32'h0000_0000, 3'd2}
    };

    initial
    begin
        gen_state = 32'd1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed table; the dig just after reset is cross-checked: row zero
        // and the last row are always solid wall
        foreach (plan[i])
        begin
            send(plan[i].c, plan[i].sd, plan[i].lv);
            if (i == 0 && (rows_due[0].walls !== '1 || rows_due[8].walls !== '1))
                note_mismatch("border", '{4'd0, '1, 1'b0}, rows_due[0]);
            short_gap();
        end
        // long receiver hold-off while the sender keeps offering transactions
        hold_off = 1'b1;
        for (int i = 0; i < 4; i++)
            send(bmg_pkg::CMD_DIG, $urandom, 3'($urandom_range(0, 7)));
        // sender pauses until every row due has come
        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(negedge clk);
        for (int i = 0; i < 255; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                send(bmg_pkg::CMD_LOAD, $urandom, 3'($urandom_range(0, 7)));
            else
                send(bmg_pkg::CMD_DIG, $urandom, 3'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) != 0)
                short_gap();
        end
        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("backtracker_maze_generator: match");
        else
            $display("backtracker_maze_generator: mismatch");
        $finish;
    end
endmodule

[files.f]
src/bmg_pkg.sv
src/bmg_ram.sv
src/bmg_datapath.sv
src/bmg_ctrl.sv
src/backtracker_maze_generator.sv
sim/tb_backtracker_maze_generator.sv
